// ===== hdl/rrts_pkg.sv =====
// Shared types and constants for the round-robin tick scheduler.
// Holds request/result structs, command codes and queue sizing.
// No dependencies.
package rrts_pkg;

	localparam int PID_W     = 4;
	localparam int PID_SPACE = 1 << PID_W;
	localparam int QDEPTH    = PID_SPACE;
	localparam int PTR_W     = $clog2(QDEPTH);
	localparam int CNT_W     = PTR_W + 1;
	localparam int SLICE_W   = 8;
	localparam int TICKS_W   = 32;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_SPAWN = 2'd2;

	localparam logic [7:0] KEY_CR = 8'd13;

	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;
	localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'hFF;

	typedef struct packed {
		logic [1:0]       cmd;
		logic             key_valid;
		logic [7:0]       key_char;
		logic [PID_W-1:0] new_pid;
	} req_t;

	typedef struct packed {
		logic [PID_W-1:0]   current_pid;
		logic               has_current;
		logic               panic;
		logic               released_valid;
		logic [PID_W-1:0]   released_pid;
		logic [TICKS_W-1:0] current_total_ticks;
	} rsp_t;

endpackage

// ===== hdl/rrts_pid_fifo.sv =====
// Circular queue of process ids with two push ports and one pop port.
// Depends on rrts_pkg for sizing.
module rrts_pid_fifo import rrts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push0_en,
	input  logic [PID_W-1:0] push0_pid,
	input  logic             push1_en,
	input  logic [PID_W-1:0] push1_pid,
	input  logic             pop_en,
	output logic [PID_W-1:0] head_pid,
	output logic [CNT_W-1:0] count
);

	logic [PID_W-1:0] slot_q [QDEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] tail1;

	assign head_pid = slot_q[head_q];
	assign count    = count_q;
	assign tail1    = push0_en ? tail_q + PTR_W'(1) : tail_q;

	always_ff @(posedge clk) begin
		if (push0_en) begin
			slot_q[tail_q] <= push0_pid;
		end
		if (push1_en) begin
			slot_q[tail1] <= push1_pid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + PTR_W'(push0_en) + PTR_W'(push1_en);
			head_q  <= head_q + PTR_W'(pop_en);
			count_q <= count_q + CNT_W'(push0_en) + CNT_W'(push1_en) - CNT_W'(pop_en);
		end
	end

endmodule

// ===== hdl/rrts_core.sv =====
// Scheduling step: queues, per-process tick table and running-process state.
// Depends on rrts_pkg and rrts_pid_fifo; result is combinational, state moves on step.
module rrts_core import rrts_pkg::*; #(
	parameter int NUM_PROCS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  req_t               req,
	input  logic [SLICE_W-1:0] time_slice,
	output rsp_t               rsp
);

	localparam int NENT  = (NUM_PROCS < PID_SPACE) ? NUM_PROCS : PID_SPACE;
	localparam int IDX_W = $clog2(NENT);

	logic                run_valid_q;
	logic [PID_W-1:0]    run_pid_q;
	logic [SLICE_W-1:0]  slice_q;
	logic [TICKS_W-1:0]  life_q;
	logic [NENT-1:0]     used_q;
	logic [TICKS_W-1:0]  life_mem [NENT];

	logic                is_tick, is_read, is_spawn;
	logic                rel, spawn_ok, preempt, park, want, has;
	logic [SLICE_W-1:0]  slice_inc;
	logic [TICKS_W-1:0]  life_inc, pop_life;
	logic                rdy_push0;
	logic [PID_W-1:0]    rdy_pid0, pop_pid;
	logic [PID_W-1:0]    ready_head, wait_head;
	logic [CNT_W-1:0]    ready_cnt, wait_cnt;
	logic                nxt_valid;
	logic [PID_W-1:0]    nxt_pid;
	logic [SLICE_W-1:0]  nxt_slice;
	logic [TICKS_W-1:0]  nxt_life;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [TICKS_W-1:0]  wr_data;

	always_comb begin
		is_tick  = 1'b0;
		is_read  = 1'b0;
		is_spawn = 1'b0;
		unique case (req.cmd)
			CMD_TICK:  is_tick  = 1'b1;
			CMD_READ:  is_read  = 1'b1;
			CMD_SPAWN: is_spawn = 1'b1;
			default: ;
		endcase
	end

	assign rel       = is_tick && req.key_valid && (req.key_char == KEY_CR) && (wait_cnt != '0);
	assign spawn_ok  = is_spawn && (int'(req.new_pid) < NENT)
			&& !used_q[req.new_pid[IDX_W-1:0]];
	assign slice_inc = (slice_q == SLICE_MAX) ? slice_q : slice_q + SLICE_W'(1);
	assign life_inc  = life_q + TICKS_W'(1);
	assign preempt   = is_tick && run_valid_q && (slice_inc >= time_slice);
	assign park      = is_read && run_valid_q;

	assign rdy_push0 = rel || spawn_ok;
	assign rdy_pid0  = rel ? wait_head : req.new_pid;

	assign want = (is_tick && (!run_valid_q || preempt)) || park;
	assign has  = (ready_cnt != '0) || rdy_push0 || preempt;

	always_comb begin
		if (ready_cnt != '0) begin
			pop_pid = ready_head;
		end else if (rdy_push0) begin
			pop_pid = rdy_pid0;
		end else begin
			pop_pid = run_pid_q;
		end
	end

	// a lone preempted process is dispatched again: its count is still in the cache
	assign pop_life = (preempt && (pop_pid == run_pid_q)) ? life_inc
			: life_mem[pop_pid[IDX_W-1:0]];

	always_comb begin
		nxt_valid = run_valid_q;
		nxt_pid   = run_pid_q;
		nxt_slice = slice_q;
		nxt_life  = life_q;
		if (want && has) begin
			nxt_valid = 1'b1;
			nxt_pid   = pop_pid;
			nxt_slice = '0;
			nxt_life  = pop_life;
		end else if (want) begin
			nxt_valid = 1'b0;
		end else if (is_tick && run_valid_q) begin
			nxt_slice = slice_inc;
			nxt_life  = life_inc;
		end
	end

	assign wr_en   = preempt || park || spawn_ok;
	assign wr_idx  = spawn_ok ? req.new_pid[IDX_W-1:0] : run_pid_q[IDX_W-1:0];
	assign wr_data = spawn_ok ? '0 : (preempt ? life_inc : life_q);

	rrts_pid_fifo u_ready_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0_en  (step && rdy_push0),
		.push0_pid (rdy_pid0),
		.push1_en  (step && preempt),
		.push1_pid (run_pid_q),
		.pop_en    (step && want && has),
		.head_pid  (ready_head),
		.count     (ready_cnt)
	);

	rrts_pid_fifo u_wait_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0_en  (step && park),
		.push0_pid (run_pid_q),
		.push1_en  (1'b0),
		.push1_pid ('0),
		.pop_en    (step && rel),
		.head_pid  (wait_head),
		.count     (wait_cnt)
	);

	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			life_mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			run_pid_q   <= '0;
			slice_q     <= '0;
			life_q      <= '0;
			used_q      <= '0;
		end else if (step) begin
			run_valid_q <= nxt_valid;
			run_pid_q   <= nxt_pid;
			slice_q     <= nxt_slice;
			life_q      <= nxt_life;
			if (spawn_ok) begin
				used_q[req.new_pid[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	always_comb begin
		rsp.current_pid         = nxt_valid ? nxt_pid : '0;
		rsp.has_current         = nxt_valid;
		rsp.panic               = want && !has && run_valid_q;
		rsp.released_valid      = rel;
		rsp.released_pid        = rel ? wait_head : '0;
		rsp.current_total_ticks = nxt_valid ? nxt_life : '0;
	end

`ifndef SYNTHESIS
	a_panic_idle : assert property (@(posedge clk) disable iff (!arst_n)
		step && rsp.panic |=> !run_valid_q)
		else $error("running process left after panic");

	a_pid_count : assert property (@(posedge clk) disable iff (!arst_n)
		(6'(ready_cnt) + 6'(wait_cnt) + 6'(run_valid_q)) <= 6'(NENT))
		else $error("more queued processes than process slots");

	a_run_spawned : assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> used_q[run_pid_q[IDX_W-1:0]])
		else $error("running process was never spawned");

	a_release_ready : assert property (@(posedge clk) disable iff (!arst_n)
		step && rel |=> (ready_cnt != '0) || run_valid_q)
		else $error("released process lost");
`endif

endmodule

// ===== hdl/round_robin_tick_scheduler.sv =====
// Top level of the round-robin tick scheduler: request register, result register, config.
// Depends on rrts_pkg and rrts_core.
//
// One request is taken each clock cycle while req_stall is low; each gives exactly one
// result: the request is held in an input register, the whole scheduling step (queue pops
// and pushes, tick counting, dispatch) runs in one pass of logic into the result register,
// and the ready and wait queues, the running-process cache and the per-process tick table
// all update at that same edge. Stall on the result side holds the result register and,
// once the request register is also full, stalls requests. Process ids are 4 bits; up to
// NUM_PROCS (at most 16 usable) processes are tracked. time_slice may be written at any
// idle time and resets to 10; cfg_ready is always high.
module round_robin_tick_scheduler import rrts_pkg::*; #(
	parameter int NUM_PROCS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [SLICE_W-1:0] cfg_data
);

	logic               req_valid_s1;
	req_t               req_s1;
	logic               rsp_valid_s2;
	rsp_t               rsp_s2;
	rsp_t               rsp_c;
	logic [SLICE_W-1:0] time_slice_q;
	logic               out_free;
	logic               adv;

	assign out_free  = !rsp_valid_s2 || !rsp_stall;
	assign adv       = req_valid_s1 && out_free;
	assign req_stall = req_valid_s1 && !out_free;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_s2;
	assign rsp_data  = rsp_s2;

	rrts_core #(
		.NUM_PROCS (NUM_PROCS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.req        (req_s1),
		.time_slice (time_slice_q),
		.rsp        (rsp_c)
	);

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req_data;
		end
		if (adv) begin
			rsp_s2 <= rsp_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_s2 <= 1'b0;
			time_slice_q <= SLICE_RESET;
		end else begin
			if (!req_stall) begin
				req_valid_s1 <= req_valid;
			end
			if (adv) begin
				rsp_valid_s2 <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_s2 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				time_slice_q <= cfg_data;
			end
		end
	end

endmodule
